/* rtl/core/modexp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_pkg: shared types for the modular exponentiation unit
// Holds the sequencer state encoding used by the top level.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // Sequencer states of the square-and-multiply control.
  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_WAIT_REDUCE,
    S_BIT,
    S_WAIT_MUL,
    S_ADVANCE,
    S_WAIT_SQR,
    S_FINISH
  } modexp_state_t;

endpackage : modexp_pkg
`default_nettype wire

/* rtl/core/modular_exponentiation_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_unit: base ^ power mod modulus
// Square-and-multiply over the exponent bits around one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken at a rising edge where start is high and busy is
//   low; base_value, power_value and modulus_value are sampled there and are
//   first cut (or zero-extended) to OPERAND_WIDTH bits. Save for base cases,
//   busy stays high until the result is issued and drops while done is high.
//   The result beat appears on result_value and bad_modulus for exactly one
//   cycle, marked by done. The receiver cannot stall, so it must take it then.
// Sequence:
//   A zero modulus, zero base or zero exponent is answered in the cycle after
//   the command. Otherwise the block reduces the base with one modular
//   multiplication, then for each exponent bit up to the highest set one it
//   runs a multiply where the bit is set and a square unless it is the last
//   bit.
// Reset:
//   rst is synchronous and returns the sequencer to idle with done low.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] base_value,
  input  logic [31:0] power_value,
  input  logic [31:0] modulus_value,
  output logic        done,
  output logic [31:0] result_value,
  output logic        bad_modulus
);

  import modexp_pkg::*;

  localparam int W = OPERAND_WIDTH;

  modexp_state_t state;
  modexp_state_t state_next;

  // Operands as seen at the internal width.
  logic [W-1:0] base_in;
  logic [W-1:0] power_in;
  logic [W-1:0] modulus_in;

  // Working registers of the exponentiation.
  logic [W-1:0] base_r;
  logic [W-1:0] power_r;
  logic [W-1:0] modulus_r;
  logic [W-1:0] square;
  logic [W-1:0] accum;

  // 1 mod m: zero when the modulus is one, so the result is reduced too.
  logic [W-1:0] one_mod;

  // Shared multiplier request and response.
  logic         mm_start;
  logic [W-1:0] mm_a;
  logic [W-1:0] mm_b;
  logic         mm_done;
  logic [W-1:0] mm_product;

  logic         accept;

  assign base_in    = W'(base_value);
  assign power_in   = W'(power_value);
  assign modulus_in = W'(modulus_value);

  assign accept  = start && (state == S_IDLE);
  assign busy    = (state != S_IDLE);
  assign one_mod = (modulus_r == W'(1)) ? '0 : W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the operand selection for the shared multiplier.
  always_comb begin
    state_next = state;
    mm_start   = 1'b0;
    mm_a       = accum;
    mm_b       = square;
    case (state)
      S_IDLE: begin
        if (accept && modulus_in != '0 && base_in != '0 && power_in != '0) begin
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        // base mod m is formed as (1 mod m) * base, with base unreduced.
        mm_start   = 1'b1;
        mm_a       = one_mod;
        mm_b       = base_r;
        state_next = S_WAIT_REDUCE;
      end
      S_WAIT_REDUCE: begin
        if (mm_done) begin
          state_next = S_BIT;
        end
      end
      S_BIT: begin
        if (power_r[0]) begin
          mm_start   = 1'b1;
          mm_a       = accum;
          mm_b       = square;
          state_next = S_WAIT_MUL;
        end else begin
          state_next = S_ADVANCE;
        end
      end
      S_WAIT_MUL: begin
        if (mm_done) begin
          state_next = S_ADVANCE;
        end
      end
      S_ADVANCE: begin
        // The square is skipped once no higher exponent bit is left.
        if (power_r[W-1:1] == '0) begin
          state_next = S_FINISH;
        end else begin
          mm_start   = 1'b1;
          mm_a       = square;
          mm_b       = square;
          state_next = S_WAIT_SQR;
        end
      end
      S_WAIT_SQR: begin
        if (mm_done) begin
          state_next = S_BIT;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Result strobe. Base cases are answered straight from the command beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && (modulus_in == '0 || base_in == '0 || power_in == '0))
              || (state == S_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base_r    <= base_in;
      power_r   <= power_in;
      modulus_r <= modulus_in;
      if (modulus_in == '0) begin
        result_value <= '0;
        bad_modulus  <= 1'b1;
      end else if (base_in == '0) begin
        result_value <= '0;
        bad_modulus  <= 1'b0;
      end else begin
        // A zero exponent gives 1 with no reduction, even for modulus one.
        result_value <= 32'd1;
        bad_modulus  <= 1'b0;
      end
    end
    case (state)
      S_WAIT_REDUCE: begin
        if (mm_done) begin
          square <= mm_product;
          accum  <= one_mod;
        end
      end
      S_WAIT_MUL: begin
        if (mm_done) begin
          accum <= mm_product;
        end
      end
      S_ADVANCE: begin
        power_r <= {1'b0, power_r[W-1:1]};
      end
      S_WAIT_SQR: begin
        if (mm_done) begin
          square <= mm_product;
        end
      end
      S_FINISH: begin
        result_value <= 32'(accum);
        bad_modulus  <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  modexp_mulmod #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .a       (mm_a),
    .b       (mm_b),
    .m       (modulus_r),
    .done    (mm_done),
    .product (mm_product)
  );

endmodule : modular_exponentiation_unit
`default_nettype wire

/* rtl/core/modexp_mulmod.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_mulmod: iterative modular multiplier
// Forms (a * b) mod m by scanning b from its most significant bit, one bit
// per cycle: double the partial sum, add a where the bit is set, reduce.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] a,
  input  logic [OPERAND_WIDTH-1:0] b,
  input  logic [OPERAND_WIDTH-1:0] m,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] product
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [W-1:0]  m_r;
  logic [W-1:0]  acc;
  logic [CW-1:0] count;
  logic          running;

  logic [W+1:0]  sum;
  logic [W+1:0]  m_once;
  logic [W+1:0]  m_twice;
  logic [W-1:0]  acc_next;

  // The partial sum and a are both below m, so sum stays below 3m and at
  // most two subtractions of m bring it back into range.
  always_comb begin
    m_once  = {2'b00, m_r};
    m_twice = {1'b0, m_r, 1'b0};
    sum     = {1'b0, acc, 1'b0} + (b_r[W-1] ? {2'b00, a_r} : '0);
    if (sum >= m_twice) begin
      acc_next = W'(sum - m_twice);
    end else if (sum >= m_once) begin
      acc_next = W'(sum - m_once);
    end else begin
      acc_next = W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start && !running) begin
        running <= 1'b1;
        count   <= CW'(W);
      end else if (running) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !running) begin
      a_r <= a;
      b_r <= b;
      m_r <= m;
      acc <= '0;
    end else if (running) begin
      acc <= acc_next;
      b_r <= {b_r[W-2:0], 1'b0};
    end
  end

  assign product = acc;

endmodule : modexp_mulmod
`default_nettype wire
